// ----- design/graph_shortest_path_engine_macros.svh -----
// assertion macros for the shortest path engine
`ifndef GRAPH_SHORTEST_PATH_ENGINE_MACROS_SVH
`define GRAPH_SHORTEST_PATH_ENGINE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define GSP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define GSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/gsp_pkg.sv -----
// shared constants, codes and helpers of the shortest path engine
package gsp_pkg;

    localparam int MAX_NODES = 64;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int CNT_W     = NODE_W + 1;
    localparam int MAX_LINKS = 8;
    localparam int LINK_W    = $clog2(MAX_LINKS);
    localparam int LCNT_W    = LINK_W + 1;
    localparam int COORD_W   = 16;
    localparam int POS_W     = 3 * COORD_W;
    localparam int COST_W    = 48;
    localparam int PAR_W     = NODE_W + 1;
    localparam logic [PAR_W-1:0] NO_PARENT = PAR_W'(MAX_NODES);

    localparam logic [2:0] OP_ADD     = 3'd0;
    localparam logic [2:0] OP_CONNECT = 3'd1;
    localparam logic [2:0] OP_PATH    = 3'd2;
    localparam logic [2:0] OP_NEAREST = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_BAD      = 3'd3;
    localparam logic [2:0] ST_LINKFULL = 3'd4;

    typedef logic signed [COORD_W-1:0] t_coord;

    function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                 input logic [COST_W-1:0] b);
        logic [COST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_W] ? {COST_W{1'b1}} : s[COST_W-1:0];
    endfunction

endpackage

// ----- design/gsp_dist.sv -----
// squared euclidean distance unit, one axis per cycle on a shared multiplier
module gsp_dist import gsp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [POS_W-1:0]  i_p,
    input  logic [POS_W-1:0]  i_q,
    output logic              o_done,
    output logic [COST_W-1:0] o_dist
);

    logic              r_busy;
    logic              r_done;
    logic [1:0]        r_step;
    logic [POS_W-1:0]  r_p;
    logic [POS_W-1:0]  r_q;
    logic [COST_W-1:0] r_acc;

    t_coord                  ca;
    t_coord                  cb;
    logic signed [COORD_W:0] diff;
    logic [COORD_W:0]        mag;
    logic [2*COORD_W+1:0]    sq;

    always_comb begin
        unique case (r_step)
            2'd0: begin
                ca = r_p[COORD_W-1:0];
                cb = r_q[COORD_W-1:0];
            end
            2'd1: begin
                ca = r_p[2*COORD_W-1:COORD_W];
                cb = r_q[2*COORD_W-1:COORD_W];
            end
            default: begin
                ca = r_p[3*COORD_W-1:2*COORD_W];
                cb = r_q[3*COORD_W-1:2*COORD_W];
            end
        endcase
        diff = {ca[COORD_W-1], ca} - {cb[COORD_W-1], cb};
        mag  = diff[COORD_W] ? (COORD_W+1)'(0) - diff : diff;
        sq   = mag * mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 2'd0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd2) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_p   <= i_p;
            r_q   <= i_q;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= sat_add(r_acc, COST_W'(sq));
        end
    end

    assign o_done = r_done;
    assign o_dist = r_acc;

endmodule

// ----- design/graph_shortest_path_engine.sv -----
// Shortest path engine over up to 64 waypoints held in synchronous memories with one read
// and one write port. An item is taken when start is high and busy is low; results leave
// one per cycle on o_valid and cannot be held off. Add node and clear answer straight
// from idle; connect reads both link counts, then writes both link entries; nearest runs
// the distance unit (one multiplier) once per node. A path query, per expanded node, scans
// the cost memory once and runs the distance unit for each link to a node not yet done,
// then walks parents into the route stack and emits the route one node per cycle.
`include "graph_shortest_path_engine_macros.svh"

module graph_shortest_path_engine import gsp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        i_opcode,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic signed [15:0] i_pos_z,
    input  logic [5:0]        i_node_a,
    input  logic [5:0]        i_node_b,
    output logic              o_valid,
    output logic [5:0]        o_node_index,
    output logic              o_last,
    output logic [2:0]        o_status
);

    typedef enum logic [16:0] {
        S_IDLE    = 17'h00001,
        S_CN_A    = 17'h00002,
        S_CN_B    = 17'h00004,
        S_CN_W    = 17'h00008,
        S_NR_RD   = 17'h00010,
        S_NR_DS   = 17'h00020,
        S_NR_WT   = 17'h00040,
        S_SCAN    = 17'h00080,
        S_SC_END  = 17'h00100,
        S_EX_RD   = 17'h00200,
        S_EX_LNK  = 17'h00400,
        S_EX_NB   = 17'h00800,
        S_EX_DS   = 17'h01000,
        S_EX_WT   = 17'h02000,
        S_RT_PUSH = 17'h04000,
        S_RT_PAR  = 17'h08000,
        S_EM      = 17'h10000
    } t_state;

    localparam int LADDR_W = NODE_W + LINK_W;

    // memories
    logic [POS_W-1:0]  r_pos_mem   [MAX_NODES];
    logic [LCNT_W-1:0] r_cnt_mem   [MAX_NODES];
    logic [NODE_W-1:0] r_link_mem  [MAX_NODES*MAX_LINKS];
    logic [COST_W-1:0] r_cost_mem  [MAX_NODES];
    logic [PAR_W-1:0]  r_par_mem   [MAX_NODES];
    logic [NODE_W-1:0] r_route_mem [MAX_NODES];

    logic [POS_W-1:0]  r_pos_q;
    logic [LCNT_W-1:0] r_cnt_q;
    logic [NODE_W-1:0] r_link_q;
    logic [COST_W-1:0] r_cost_q;
    logic [PAR_W-1:0]  r_par_q;
    logic [NODE_W-1:0] r_route_q;

    logic               pos_we, cnt_we, link_we, cost_we, par_we, route_we;
    logic [NODE_W-1:0]  pos_wa, pos_ra, cnt_wa, cnt_ra, cost_wa, cost_ra;
    logic [NODE_W-1:0]  par_wa, par_ra, route_wa, route_ra;
    logic [LADDR_W-1:0] link_wa, link_ra;
    logic [POS_W-1:0]   pos_wd;
    logic [LCNT_W-1:0]  cnt_wd;
    logic [NODE_W-1:0]  link_wd, route_wd;
    logic [COST_W-1:0]  cost_wd;
    logic [PAR_W-1:0]   par_wd;

    // control registers
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [NODE_W-1:0] r_a, n_a, r_b, n_b;
    logic [POS_W-1:0]  r_p, n_p;
    logic [LCNT_W-1:0] r_ca, n_ca, r_cb, n_cb, r_lc, n_lc, r_j, n_j;
    logic [CNT_W-1:0]  r_i, n_i, r_depth, n_depth, r_k, n_k;
    logic              r_sv, n_sv, r_found, n_found, r_ev, n_ev;
    logic [NODE_W-1:0] r_id, n_id, r_cur, n_cur, r_nb, n_nb;
    logic [COST_W-1:0] r_bcost, n_bcost, r_ncost, n_ncost;
    logic [POS_W-1:0]  r_pcur, n_pcur;
    logic [MAX_NODES-1:0] r_open, n_open, r_done, n_done;
    logic              r_o_valid, n_o_valid, r_o_last, n_o_last;
    logic [NODE_W-1:0] r_o_idx, n_o_idx;
    logic [2:0]        r_o_st, n_o_st;

    logic              dist_start, dist_done;
    logic [POS_W-1:0]  dist_p;
    logic [COST_W-1:0] dist_val;

    logic              accept;
    logic [LCNT_W-1:0] cbx;
    logic [COST_W-1:0] t_cost;
    logic              better;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    gsp_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dist_start),
        .i_p     (dist_p),
        .i_q     (r_pos_q),
        .o_done  (dist_done),
        .o_dist  (dist_val)
    );

    assign dist_start = (r_state == S_NR_DS) || (r_state == S_EX_DS);
    assign dist_p     = (r_state == S_EX_DS) ? r_pcur : r_p;
    assign t_cost     = sat_add(r_bcost, dist_val);
    assign cbx        = (r_a == r_b) ? r_ca + LCNT_W'(1) : r_cnt_q;
    assign better     = (r_i == '0) || (dist_val < r_bcost);

    always_comb begin
        n_state = r_state;  n_count = r_count;  n_a = r_a;  n_b = r_b;  n_p = r_p;
        n_ca = r_ca;  n_cb = r_cb;  n_lc = r_lc;  n_j = r_j;  n_i = r_i;
        n_depth = r_depth;  n_k = r_k;  n_sv = r_sv;  n_found = r_found;  n_ev = r_ev;
        n_id = r_id;  n_cur = r_cur;  n_nb = r_nb;  n_bcost = r_bcost;  n_ncost = r_ncost;
        n_pcur = r_pcur;  n_open = r_open;  n_done = r_done;
        n_o_valid = 1'b0;  n_o_last = 1'b1;  n_o_idx = '0;  n_o_st = ST_OK;

        pos_we = 1'b0;  pos_wa = r_count[NODE_W-1:0];  pos_wd = {i_pos_z, i_pos_y, i_pos_x};
        pos_ra = r_cur;
        cnt_we = 1'b0;  cnt_wa = r_a;  cnt_wd = '0;  cnt_ra = r_cur;
        link_we = 1'b0;  link_wa = {r_a, r_ca[LINK_W-1:0]};  link_wd = r_b;
        link_ra = {r_cur, r_j[LINK_W-1:0]};
        cost_we = 1'b0;  cost_wa = r_nb;  cost_wd = t_cost;  cost_ra = r_i[NODE_W-1:0];
        par_we = 1'b0;  par_wa = r_nb;  par_wd = PAR_W'(r_cur);  par_ra = r_cur;
        route_we = 1'b0;  route_wa = r_depth[NODE_W-1:0];  route_wd = r_cur;
        route_ra = NODE_W'(r_depth - CNT_W'(1) - r_k);

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_a = i_node_a;
                    n_b = i_node_b;
                    n_p = {i_pos_z, i_pos_y, i_pos_x};
                    unique case (i_opcode)
                        OP_ADD: begin
                            n_o_valid = 1'b1;
                            if (r_count >= CNT_W'(MAX_NODES)) begin
                                n_o_st = ST_FULL;
                            end else begin
                                pos_we    = 1'b1;
                                cnt_we    = 1'b1;
                                cnt_wa    = r_count[NODE_W-1:0];
                                n_o_idx   = r_count[NODE_W-1:0];
                                n_count   = r_count + CNT_W'(1);
                            end
                        end
                        OP_CONNECT: begin
                            if (CNT_W'(i_node_a) >= r_count || CNT_W'(i_node_b) >= r_count) begin
                                n_o_valid = 1'b1;
                                n_o_st    = ST_BAD;
                            end else begin
                                cnt_ra  = i_node_a;
                                n_state = S_CN_A;
                            end
                        end
                        OP_PATH: begin
                            if (r_count == '0) begin
                                n_o_valid = 1'b1;
                                n_o_st    = ST_EMPTY;
                            end else if (CNT_W'(i_node_a) >= r_count ||
                                         CNT_W'(i_node_b) >= r_count) begin
                                n_o_valid = 1'b1;
                                n_o_st    = ST_BAD;
                            end else begin
                                cost_we = 1'b1;
                                cost_wa = i_node_a;
                                cost_wd = '0;
                                par_we  = 1'b1;
                                par_wa  = i_node_a;
                                par_wd  = NO_PARENT;
                                n_open  = '0;
                                n_open[i_node_a] = 1'b1;
                                n_done  = '0;
                                n_i     = '0;
                                n_sv    = 1'b0;
                                n_found = 1'b0;
                                n_state = S_SCAN;
                            end
                        end
                        OP_NEAREST: begin
                            if (r_count == '0) begin
                                n_o_valid = 1'b1;
                                n_o_st    = ST_EMPTY;
                            end else begin
                                n_i     = '0;
                                n_state = S_NR_RD;
                            end
                        end
                        OP_CLEAR: begin
                            n_count   = '0;
                            n_open    = '0;
                            n_done    = '0;
                            n_o_valid = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CN_A: begin
                n_ca    = r_cnt_q;
                cnt_ra  = r_b;
                n_state = S_CN_B;
            end
            S_CN_B: begin
                if ((r_a == r_b && ({1'b0, r_ca} + (LCNT_W+1)'(2)) > (LCNT_W+1)'(MAX_LINKS)) ||
                    r_ca >= LCNT_W'(MAX_LINKS) || r_cnt_q >= LCNT_W'(MAX_LINKS)) begin
                    n_o_valid = 1'b1;
                    n_o_st    = ST_LINKFULL;
                    n_state   = S_IDLE;
                end else begin
                    link_we = 1'b1;
                    cnt_we  = 1'b1;
                    cnt_wd  = r_ca + LCNT_W'(1);
                    n_cb    = cbx;
                    n_state = S_CN_W;
                end
            end
            S_CN_W: begin
                link_we   = 1'b1;
                link_wa   = {r_b, r_cb[LINK_W-1:0]};
                link_wd   = r_a;
                cnt_we    = 1'b1;
                cnt_wa    = r_b;
                cnt_wd    = r_cb + LCNT_W'(1);
                n_o_valid = 1'b1;
                n_o_idx   = r_a;
                n_state   = S_IDLE;
            end
            S_NR_RD: begin
                pos_ra  = r_i[NODE_W-1:0];
                n_state = S_NR_DS;
            end
            S_NR_DS: begin
                n_state = S_NR_WT;
            end
            S_NR_WT: begin
                if (dist_done) begin
                    if (better) begin
                        n_bcost = dist_val;
                        n_cur   = r_i[NODE_W-1:0];
                    end
                    if (r_i + CNT_W'(1) == r_count) begin
                        n_o_valid = 1'b1;
                        n_o_idx   = better ? r_i[NODE_W-1:0] : r_cur;
                        n_state   = S_IDLE;
                    end else begin
                        n_i     = r_i + CNT_W'(1);
                        n_state = S_NR_RD;
                    end
                end
            end
            S_SCAN: begin
                // compare the entry read last cycle, lowest index wins ties
                if (r_sv && r_open[r_id] && (!r_found || r_cost_q < r_bcost)) begin
                    n_found = 1'b1;
                    n_cur   = r_id;
                    n_bcost = r_cost_q;
                end
                if (r_i < r_count) begin
                    n_id = r_i[NODE_W-1:0];
                    n_sv = 1'b1;
                    n_i  = r_i + CNT_W'(1);
                end else begin
                    n_sv    = 1'b0;
                    n_state = S_SC_END;
                end
            end
            S_SC_END: begin
                if (!r_found) begin
                    n_o_valid = 1'b1;
                    n_o_st    = ST_EMPTY;
                    n_state   = S_IDLE;
                end else if (r_cur == r_b) begin
                    n_depth = '0;
                    n_state = S_RT_PUSH;
                end else begin
                    n_open[r_cur] = 1'b0;
                    n_done[r_cur] = 1'b1;
                    n_j     = '0;
                    n_state = S_EX_RD;
                end
            end
            S_EX_RD: begin
                n_pcur  = r_pos_q;
                n_lc    = r_cnt_q;
                n_state = S_EX_LNK;
            end
            S_EX_LNK: begin
                if (r_j < r_lc) begin
                    n_state = S_EX_NB;
                end else begin
                    n_i     = '0;
                    n_sv    = 1'b0;
                    n_found = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_EX_NB: begin
                n_nb = r_link_q;
                n_j  = r_j + LCNT_W'(1);
                if (CNT_W'(r_link_q) >= r_count || r_done[r_link_q]) begin
                    n_state = S_EX_LNK;
                end else begin
                    pos_ra  = r_link_q;
                    cost_ra = r_link_q;
                    n_state = S_EX_DS;
                end
            end
            S_EX_DS: begin
                n_ncost = r_cost_q;
                n_state = S_EX_WT;
            end
            S_EX_WT: begin
                if (dist_done) begin
                    if (!r_open[r_nb] || t_cost < r_ncost) begin
                        cost_we       = 1'b1;
                        par_we        = 1'b1;
                        n_open[r_nb]  = 1'b1;
                    end
                    n_state = S_EX_LNK;
                end
            end
            S_RT_PUSH: begin
                route_we = 1'b1;
                n_depth  = r_depth + CNT_W'(1);
                n_state  = S_RT_PAR;
            end
            S_RT_PAR: begin
                if (CNT_W'(r_par_q) >= r_count || r_depth == CNT_W'(MAX_NODES)) begin
                    n_k     = '0;
                    n_ev    = 1'b0;
                    n_state = S_EM;
                end else begin
                    n_cur   = r_par_q[NODE_W-1:0];
                    n_state = S_RT_PUSH;
                end
            end
            S_EM: begin
                // route stack is read in reverse, one node per cycle
                if (r_ev) begin
                    n_o_valid = 1'b1;
                    n_o_idx   = r_route_q;
                    n_o_last  = (r_k == r_depth);
                end
                if (r_k < r_depth) begin
                    n_k  = r_k + CNT_W'(1);
                    n_ev = 1'b1;
                end else begin
                    n_ev    = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_open    <= '0;
            r_done    <= '0;
            r_o_valid <= 1'b0;
            r_sv      <= 1'b0;
            r_ev      <= 1'b0;
            r_found   <= 1'b0;
            r_depth   <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_open    <= n_open;
            r_done    <= n_done;
            r_o_valid <= n_o_valid;
            r_sv      <= n_sv;
            r_ev      <= n_ev;
            r_found   <= n_found;
            r_depth   <= n_depth;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;  r_b <= n_b;  r_p <= n_p;  r_ca <= n_ca;  r_cb <= n_cb;
        r_lc <= n_lc;  r_j <= n_j;  r_i <= n_i;  r_k <= n_k;
        r_id <= n_id;  r_cur <= n_cur;  r_nb <= n_nb;  r_bcost <= n_bcost;
        r_ncost <= n_ncost;  r_pcur <= n_pcur;
        r_o_last <= n_o_last;  r_o_idx <= n_o_idx;  r_o_st <= n_o_st;
    end

    always_ff @(posedge i_clk) begin
        if (pos_we) r_pos_mem[pos_wa] <= pos_wd;
        r_pos_q <= r_pos_mem[pos_ra];
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) r_cnt_mem[cnt_wa] <= cnt_wd;
        r_cnt_q <= r_cnt_mem[cnt_ra];
    end

    always_ff @(posedge i_clk) begin
        if (link_we) r_link_mem[link_wa] <= link_wd;
        r_link_q <= r_link_mem[link_ra];
    end

    always_ff @(posedge i_clk) begin
        if (cost_we) r_cost_mem[cost_wa] <= cost_wd;
        r_cost_q <= r_cost_mem[cost_ra];
    end

    always_ff @(posedge i_clk) begin
        if (par_we) r_par_mem[par_wa] <= par_wd;
        r_par_q <= r_par_mem[par_ra];
    end

    always_ff @(posedge i_clk) begin
        if (route_we) r_route_mem[route_wa] <= route_wd;
        r_route_q <= r_route_mem[route_ra];
    end

    assign o_valid      = r_o_valid;
    assign o_node_index = r_o_idx;
    assign o_last       = r_o_last;
    assign o_status     = r_o_st;

    `GSP_ASSERT_NEXT(a_no_spurious, !busy && !start, !o_valid, "result without a transfer")
    `GSP_ASSERT_NOW(a_err_is_last, o_valid && o_status != ST_OK, o_last, "error not last")
    `GSP_ASSERT_NOW(a_count_range, 1'b1, r_count <= CNT_W'(MAX_NODES), "node count overflow")
    `GSP_ASSERT_NOW(a_depth_range, 1'b1, r_depth <= CNT_W'(MAX_NODES), "route depth overflow")

endmodule
